>>> hw/rtl/gbkuc_pkg.sv
// Shared types and constants of the GBK / UTF-16 table converter.
// No dependencies; the string controller, result queue, top level and testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package gbkuc_pkg;

   // Operation codes carried by a request transfer.
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_DECODE = 2'd1;
   localparam logic [1:0] OP_ENCODE = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // Character set constants.
   localparam logic [7:0]  ASCII_LIMIT    = 8'd128;
   localparam logic [7:0]  LEAD_BASE      = 8'd129;
   localparam logic [15:0] CJK_FIRST      = 16'h4E00;
   localparam logic [15:0] CJK_LAST       = 16'h9FA5;
   localparam logic [15:0] CJK_TABLE_BASE = 16'd32004;
   localparam logic [15:0] CHAR_QMARK     = 16'h003F;
   localparam logic [15:0] BYTE_LIMIT     = 16'd256;
   localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

   // Result queue geometry.
   localparam int MAX_RESULTS = 3;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_PTR_W  = 3;
   localparam int FIFO_CNT_W  = 4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] table_index;
      logic [15:0] table_word;
      logic [7:0]  byte_in;
      logic [15:0] char_in;
      logic        first_item;
      logic        last_item;
   } req_item_type;

   // How the result stage turns one item into result entries.
   typedef enum logic [1:0] {
      RES_NONE,
      RES_LITERAL,
      RES_WORD,
      RES_BYTES
   } res_mode_type;

   typedef struct packed {
      res_mode_type mode;
      logic [15:0]  literal;
      logic         literal_eos;
      logic         add_term;
   } res_desc_type;

   typedef struct packed {
      logic [15:0] value;
      logic        eos;
   } res_entry_type;

   typedef struct packed {
      logic [FIFO_CNT_W-1:0] count;
      logic                  space_ok;
      logic                  not_empty;
   } fifo_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/gbkuc_if.sv
// Handshake channel interfaces of the converter: request, result and register write.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface gbkuc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] table_index;
   logic [15:0] table_word;
   logic [7:0]  byte_in;
   logic [15:0] char_in;
   logic        first_item;
   logic        last_item;

   modport source (output valid, operation, table_index, table_word, byte_in, char_in,
                   first_item, last_item, input ready);
   modport sink (input valid, operation, table_index, table_word, byte_in, char_in,
                 first_item, last_item, output ready);
endinterface

interface gbkuc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] out_value;
   logic        end_of_string;

   modport source (output valid, out_value, end_of_string, input ready);
   modport sink (input valid, out_value, end_of_string, output ready);
endinterface

interface gbkuc_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gbkuc_code_ram.sv
// Code table storage: single write port, one read port with registered data.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps
`default_nettype none

module gbkuc_code_ram #(
   parameter int TABLE_DEPTH = 65536,
   parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [15:0]       wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]            rd_data
);

   logic [15:0] mem_ff [TABLE_DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/gbkuc_string_ctrl.sv
// Per-string state and item interpretation; issues table reads and writes.
// Depends on gbkuc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbkuc_string_ctrl #(
   parameter int TABLE_DEPTH = 65536,
   parameter int ADDR_W      = $clog2(TABLE_DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire gbkuc_pkg::req_item_type item,
   input  wire logic [15:0]           max_length,
   output logic                       wr_en,
   output logic [ADDR_W-1:0]          wr_addr,
   output logic [15:0]                wr_data,
   output logic                       rd_en,
   output logic [ADDR_W-1:0]          rd_addr,
   output gbkuc_pkg::res_desc_type    desc
);
   import gbkuc_pkg::*;

   logic [7:0]   pending_lead_ff, pending_lead_in;
   logic         lead_waiting_ff, lead_waiting_in;
   logic [15:0]  item_count_ff, item_count_in;
   logic         string_done_ff, string_done_in;
   res_desc_type desc_ff, desc_in;

   logic [7:0]  lead_eff;
   logic        waiting_eff;
   logic [15:0] count_eff;
   logic        done_eff;
   logic [15:0] count_inc;
   logic [7:0]  lead_off;
   logic [15:0] dec_idx;
   logic [15:0] enc_idx;
   logic        idx_in_range;
   logic        enc_allowed;

   always_comb begin
      lead_eff    = item.first_item ? 8'd0  : pending_lead_ff;
      waiting_eff = item.first_item ? 1'b0  : lead_waiting_ff;
      count_eff   = item.first_item ? 16'd0 : item_count_ff;
      done_eff    = item.first_item ? 1'b0  : string_done_ff;
      count_inc   = (count_eff == COUNT_MAX) ? count_eff : count_eff + 16'd1;
      // Row of the lead byte times 127, plus the column of the trail byte.
      lead_off    = lead_eff - LEAD_BASE;
      dec_idx     = {1'b0, lead_off, 7'd0} - {8'd0, lead_off} + {9'd0, item.byte_in[6:0]};
      enc_idx     = item.char_in - CJK_FIRST + CJK_TABLE_BASE;
      idx_in_range = ({1'b0, item.table_index} < 17'(TABLE_DEPTH));
      enc_allowed = (max_length == 16'd0) || (count_eff < max_length);
   end

   always_comb begin
      pending_lead_in = pending_lead_ff;
      lead_waiting_in = lead_waiting_ff;
      item_count_in   = item_count_ff;
      string_done_in  = string_done_ff;
      desc_in         = '{mode: RES_NONE, literal: 16'd0, literal_eos: 1'b0, add_term: 1'b0};
      wr_en           = 1'b0;
      rd_en           = 1'b0;
      rd_addr         = ADDR_W'(dec_idx);
      if (accept) begin
         case (item.operation)
            OP_WRITE: begin
               wr_en = idx_in_range;
            end
            OP_DECODE: begin
               pending_lead_in = lead_eff;
               lead_waiting_in = waiting_eff;
               item_count_in   = count_eff;
               string_done_in  = done_eff;
               if (!done_eff) begin
                  if (waiting_eff) begin
                     pending_lead_in = 8'd0;
                     lead_waiting_in = 1'b0;
                     item_count_in   = count_inc;
                     if (item.byte_in == 8'd0) begin
                        desc_in.mode        = RES_LITERAL;
                        desc_in.literal_eos = 1'b1;
                        string_done_in      = 1'b1;
                     end else if (item.byte_in < ASCII_LIMIT) begin
                        desc_in.mode    = RES_LITERAL;
                        desc_in.literal = {8'd0, item.byte_in};
                     end else begin
                        desc_in.mode = RES_WORD;
                        rd_en        = 1'b1;
                        rd_addr      = ADDR_W'(dec_idx);
                     end
                  end else if (item.byte_in == 8'd0) begin
                     desc_in.mode        = RES_LITERAL;
                     desc_in.literal_eos = 1'b1;
                     string_done_in      = 1'b1;
                  end else begin
                     item_count_in = count_inc;
                     if (max_length != 16'd0 && count_inc >= max_length) begin
                        desc_in.mode        = RES_LITERAL;
                        desc_in.literal_eos = 1'b1;
                        string_done_in      = 1'b1;
                     end else if (item.byte_in <= ASCII_LIMIT) begin
                        desc_in.mode    = RES_LITERAL;
                        desc_in.literal = {8'd0, item.byte_in};
                     end else begin
                        pending_lead_in = item.byte_in;
                        lead_waiting_in = 1'b1;
                     end
                  end
               end
            end
            OP_ENCODE: begin
               pending_lead_in = lead_eff;
               lead_waiting_in = waiting_eff;
               item_count_in   = count_eff;
               string_done_in  = done_eff;
               if (!done_eff) begin
                  item_count_in = count_inc;
                  if (enc_allowed) begin
                     if (item.char_in < BYTE_LIMIT) begin
                        desc_in.mode    = RES_LITERAL;
                        desc_in.literal = item.char_in;
                     end else if (item.char_in inside {[CJK_FIRST:CJK_LAST]}) begin
                        desc_in.mode = RES_BYTES;
                        rd_en        = 1'b1;
                        rd_addr      = ADDR_W'(enc_idx);
                     end else begin
                        desc_in.mode    = RES_LITERAL;
                        desc_in.literal = CHAR_QMARK;
                     end
                  end
                  if (item.last_item) begin
                     desc_in.add_term = 1'b1;
                     string_done_in   = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign wr_addr = ADDR_W'(item.table_index);
   assign wr_data = item.table_word;
   assign desc    = desc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_lead_ff <= 8'd0;
         lead_waiting_ff <= 1'b0;
         item_count_ff   <= 16'd0;
         string_done_ff  <= 1'b0;
         desc_ff         <= '{mode: RES_NONE, literal: 16'd0, literal_eos: 1'b0,
                              add_term: 1'b0};
      end else begin
         pending_lead_ff <= pending_lead_in;
         lead_waiting_ff <= lead_waiting_in;
         item_count_ff   <= item_count_in;
         string_done_ff  <= string_done_in;
         desc_ff         <= desc_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/gbkuc_result_fifo.sv
// Expands an item descriptor plus table data into result entries and queues them.
// Depends on gbkuc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbkuc_result_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire gbkuc_pkg::res_desc_type desc,
   input  wire logic [15:0]            rd_data,
   input  wire logic                   pop,
   output gbkuc_pkg::res_entry_type    head,
   output gbkuc_pkg::fifo_status_type  status
);
   import gbkuc_pkg::*;

   res_entry_type         entries_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   res_entry_type ent [MAX_RESULTS];
   logic [1:0]    base_n;
   logic [1:0]    push_n;

   always_comb begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         ent[k] = '{value: 16'd0, eos: 1'b0};
      end
      base_n = 2'd0;
      case (desc.mode)
         RES_LITERAL: begin
            ent[0] = '{value: desc.literal, eos: desc.literal_eos};
            base_n = 2'd1;
         end
         RES_WORD: begin
            ent[0] = '{value: rd_data, eos: 1'b0};
            base_n = 2'd1;
         end
         RES_BYTES: begin
            ent[0] = '{value: {8'd0, rd_data[15:8]}, eos: 1'b0};
            ent[1] = '{value: {8'd0, rd_data[7:0]}, eos: 1'b0};
            base_n = 2'd2;
         end
         default: begin
         end
      endcase
      if (desc.add_term) begin
         ent[base_n] = '{value: 16'd0, eos: 1'b1};
      end
      push_n = base_n + {1'b0, desc.add_term};
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (2'(k) < push_n) begin
            entries_ff[wr_ptr_ff + FIFO_PTR_W'(k)] <= ent[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head             = entries_ff[rd_ptr_ff];
   assign status.count     = count_ff;
   assign status.not_empty = (count_ff != '0);
   // Room for every result of the item in flight and of one more item.
   assign status.space_ok  = ((count_ff + FIFO_CNT_W'(push_n))
                              <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));

endmodule

`default_nettype wire

>>> hw/rtl/gbk_unicode_table_converter_unit.sv
// Top level of the GBK / UTF-16 table converter.
// Depends on gbkuc_pkg, gbkuc_if, gbkuc_code_ram, gbkuc_string_ctrl and gbkuc_result_fifo.
`timescale 1ns / 1ps
`default_nettype none

// The converter holds a 16-bit code table, loaded one word per request transfer, and
// converts a GBK byte stream to UTF-16 units or UTF-16 units to GBK bytes. A request
// is taken whenever the result queue has room for all three results that an item
// may produce, so a stream runs at one item per cycle while the queue keeps that room.
// Each item makes at most one table read in the synchronous memory, issued in the
// cycle it is accepted; its results enter the eight-entry result queue on the
// following cycle and are shown from its head. Results leave one per cycle while
// the result port is ready, so encoding Chinese characters (two bytes each) is
// paced by the result port. The table has no clearing pass and is usable straight
// after reset; an entry must be written before any string reads it. The max_length
// register is written through the csr channel, which always accepts; it should be
// changed only while no string conversion is in progress.
module gbk_unicode_table_converter_unit #(
   parameter int TABLE_DEPTH = 65536
) (
   input wire logic         clock,
   input wire logic         reset,
   gbkuc_req_if.sink        req_ch,
   gbkuc_rsp_if.source      rsp_ch,
   gbkuc_csr_if.sink        csr_ch
);
   import gbkuc_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   logic [15:0]     max_length_ff, max_length_in;
   req_item_type    req_item;
   logic            req_accept;
   logic            rsp_pop;
   logic            wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [15:0]     wr_data;
   logic            rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [15:0]     rd_data;
   res_desc_type    desc;
   res_entry_type   head;
   fifo_status_type fifo_status;

   // The register write channel never stalls.
   assign csr_ch.ready  = 1'b1;
   assign max_length_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.data : max_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= 16'd0;
      end else begin
         max_length_ff <= max_length_in;
      end
   end

   // Requests are taken whenever the queue can absorb the worst-case results.
   assign req_ch.ready = fifo_status.space_ok;
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign req_item     = '{operation:   req_ch.operation,
                           table_index: req_ch.table_index,
                           table_word:  req_ch.table_word,
                           byte_in:     req_ch.byte_in,
                           char_in:     req_ch.char_in,
                           first_item:  req_ch.first_item,
                           last_item:   req_ch.last_item};

   gbkuc_string_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .item       (req_item),
      .max_length (max_length_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .desc       (desc)
   );

   // A table write and a later read of the same entry always fall in different
   // cycles, so the memory needs no forwarding path.
   gbkuc_code_ram #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_W      (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gbkuc_result_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .desc    (desc),
      .rd_data (rd_data),
      .pop     (rsp_pop),
      .head    (head),
      .status  (fifo_status)
   );

   // Results are shown from the head of the queue.
   assign rsp_ch.valid         = fifo_status.not_empty;
   assign rsp_ch.out_value     = head.value;
   assign rsp_ch.end_of_string = head.eos;
   assign rsp_pop              = rsp_ch.valid && rsp_ch.ready;

   // The queue must never be filled past its depth.
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.count <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   // A table write produces no results in the following cycle.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_ch.operation == OP_WRITE)
      |=> (desc.mode == RES_NONE && !desc.add_term))
      else $error("table write produced a result");

   // A terminator result always carries a zero value.
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.end_of_string) |-> (rsp_ch.out_value == 16'd0))
      else $error("terminator with nonzero value");

   // A request is only taken while the queue has room for three more results.
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (fifo_status.count <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS)))
      else $error("request taken without queue room");

endmodule

`default_nettype wire

>>> tb/sv/gbk_unicode_table_converter_unit_test.sv
// Self-checking testbench for gbk_unicode_table_converter_unit: table load, decode, encode.
// Depends on gbkuc_pkg, the gbkuc_*_if channel interfaces and the converter RTL.
// A built-in predictor keeps its own state and table and checks every result transfer in order.
`timescale 1ns / 1ps

module gbk_unicode_table_converter_unit_test;
   import gbkuc_pkg::*;

   // Number of trail byte values that share one lead byte row of the table.
   localparam int unsigned TRAIL_SPAN = 127;
   // Number of byte values above 128 that the stimulus uses as lead or trail bytes.
   localparam int unsigned HIGH_COUNT = 5;
   // Number of CJK units that the stimulus encodes.
   localparam int unsigned CJK_COUNT = 6;
   // Quiet cycles (no transfer on any channel) before the run is declared hung.
   localparam int QUIET_LIMIT = 1000;
   // Cycles allowed after the last expected result before a register write or the end.
   localparam int DRAIN_CYCLES = 12;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gbkuc_req_if req_bus ();
   gbkuc_rsp_if rsp_bus ();
   gbkuc_csr_if csr_bus ();

   gbk_unicode_table_converter_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Items waiting for the driver, and results the predictor says are still to come.
   req_item_type  pending_items[$];
   res_entry_type due_results[$];

   // Predictor state. Only the entries that the stimulus can reach are loaded, before
   // any string is converted, so no read ever sees an unwritten entry.
   logic [15:0] code_words [0:65535];
   logic [7:0]  held_lead = '0;
   logic        lead_held = 1'b0;
   logic [15:0] char_count = '0;
   logic        string_closed = 1'b0;
   logic [15:0] max_len = '0;

   int fault_count = 0;
   int quiet_cycles = 0;
   int send_gap = 0;
   int stall_left = 0;
   // Set for the last part of the run, where neither side idles.
   bit calm = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The byte values above 128 that may appear as lead or trail bytes.
   function automatic logic [7:0] high_byte(input int unsigned k);
      case (k)
         0: return 8'h81;
         1: return 8'h95;
         2: return 8'hA0;
         3: return 8'hC1;
         default: return 8'hFF;
      endcase
   endfunction

   // The CJK units that may be encoded, both ends of the range included.
   function automatic logic [15:0] cjk_unit(input int unsigned k);
      case (k)
         0: return CJK_FIRST;
         1: return 16'h4E01;
         2: return 16'h6A5B;
         3: return 16'h8000;
         4: return 16'h9FA4;
         default: return CJK_LAST;
      endcase
   endfunction

   function automatic logic [7:0] random_high();
      return high_byte($urandom_range(HIGH_COUNT - 1));
   endfunction

   // A trail byte of 128 or one of the high bytes.
   function automatic logic [7:0] random_trail();
      if ($urandom_range(5) == 0)
         return ASCII_LIMIT;
      return random_high();
   endfunction

   function automatic logic [15:0] random_cjk();
      return cjk_unit($urandom_range(CJK_COUNT - 1));
   endfunction

   function automatic void expect_result(input logic [15:0] value, input logic eos);
      res_entry_type r;
      r.value = value;
      r.eos   = eos;
      due_results.push_back(r);
   endfunction

   // Works out what one accepted request transfer produces and updates the state.
   function automatic void convert_item(input req_item_type it);
      int unsigned b;
      int unsigned c;
      int unsigned lead;
      int unsigned idx;
      logic [15:0] word;
      logic        allowed;
      b = it.byte_in;
      c = it.char_in;
      // Table loads never touch the string state, whatever the marker bits say.
      if (it.operation == OP_WRITE) begin
         code_words[it.table_index] = it.table_word;
         return;
      end
      if (it.operation == OP_NONE)
         return;
      if (it.first_item) begin
         char_count    = '0;
         held_lead     = '0;
         lead_held     = 1'b0;
         string_closed = 1'b0;
      end
      // A closed string swallows everything until the next first item.
      if (string_closed)
         return;
      if (it.operation == OP_DECODE) begin
         if (lead_held) begin
            // Trail byte: it always counts, and a zero ends the string and drops the lead.
            lead      = held_lead;
            lead_held = 1'b0;
            held_lead = '0;
            if (char_count != COUNT_MAX)
               char_count++;
            if (b == 0) begin
               expect_result('0, 1'b1);
               string_closed = 1'b1;
            end else if (b < ASCII_LIMIT) begin
               expect_result(16'(b), 1'b0);
            end else begin
               idx = (lead - LEAD_BASE) * TRAIL_SPAN + (b - ASCII_LIMIT);
               expect_result(code_words[idx], 1'b0);
            end
         end else if (b == 0) begin
            expect_result('0, 1'b1);
            string_closed = 1'b1;
         end else begin
            if (char_count != COUNT_MAX)
               char_count++;
            // The length limit is only checked on a lead position byte.
            if (max_len != 0 && char_count >= max_len) begin
               expect_result('0, 1'b1);
               string_closed = 1'b1;
            end else if (b <= ASCII_LIMIT) begin
               expect_result(16'(b), 1'b0);
            end else begin
               held_lead = 8'(b);
               lead_held = 1'b1;
            end
         end
      end else begin
         // Encoding leaves any held lead byte alone but shares the count.
         allowed = (max_len == 0) || (char_count < max_len);
         if (char_count != COUNT_MAX)
            char_count++;
         if (allowed) begin
            if (c < BYTE_LIMIT) begin
               expect_result(16'(c), 1'b0);
            end else if (c >= CJK_FIRST && c <= CJK_LAST) begin
               idx  = c - CJK_FIRST + CJK_TABLE_BASE;
               word = code_words[idx];
               expect_result({8'h00, word[15:8]}, 1'b0);
               expect_result({8'h00, word[7:0]}, 1'b0);
            end else begin
               expect_result(CHAR_QMARK, 1'b0);
            end
         end
         // The terminator comes even when the limit has cut off the unit itself.
         if (it.last_item) begin
            expect_result('0, 1'b1);
            string_closed = 1'b1;
         end
      end
   endfunction

   // An item with every field random; callers overwrite the fields that matter.
   function automatic req_item_type any_item();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return req_item_type'(bits[59:0]);
   endfunction

   function automatic req_item_type byte_item(input logic [7:0] b, input logic first);
      req_item_type it;
      it = any_item();
      it.operation  = OP_DECODE;
      it.byte_in    = b;
      it.first_item = first;
      return it;
   endfunction

   function automatic req_item_type unit_item(input logic [15:0] c, input logic first,
                                              input logic last);
      req_item_type it;
      it = any_item();
      it.operation  = OP_ENCODE;
      it.char_in    = c;
      it.first_item = first;
      it.last_item  = last;
      return it;
   endfunction

   function automatic req_item_type load_item(input logic [15:0] idx);
      req_item_type it;
      it = any_item();
      it.operation   = OP_WRITE;
      it.table_index = idx;
      return it;
   endfunction

   // Request driver. A new item is put on the bus only once the previous transfer
   // has happened; random idle bursts follow some transfers.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_item_type it;
            it = pending_items.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.operation   <= it.operation;
            req_bus.table_index <= it.table_index;
            req_bus.table_word  <= it.table_word;
            req_bus.byte_in     <= it.byte_in;
            req_bus.char_in     <= it.char_in;
            req_bus.first_item  <= it.first_item;
            req_bus.last_item   <= it.last_item;
            if (!calm && $urandom_range(7) == 0)
               send_gap = $urandom_range(1, 11);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result sink: ready drops for random bursts so that back pressure reaches the queue.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!calm && $urandom_range(5) == 0)
            stall_left = $urandom_range(1, 11);
      end
   end

   // Monitor: register writes and accepted requests feed the predictor, and every
   // result transfer is compared with the oldest outstanding expectation.
   always @(posedge clock) begin
      res_entry_type want;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            max_len = csr_bus.data;
         if (req_bus.valid && req_bus.ready)
            convert_item(req_item_type'{
               operation:   req_bus.operation,
               table_index: req_bus.table_index,
               table_word:  req_bus.table_word,
               byte_in:     req_bus.byte_in,
               char_in:     req_bus.char_in,
               first_item:  req_bus.first_item,
               last_item:   req_bus.last_item});
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result out_value=%h end_of_string=%b", $time,
                        rsp_bus.out_value, rsp_bus.end_of_string);
               fault_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_bus.out_value !== want.value) begin
                  $display("%0t: out_value expected %h actual %h", $time, want.value,
                           rsp_bus.out_value);
                  fault_count++;
               end
               if (rsp_bus.end_of_string !== want.eos) begin
                  $display("%0t: end_of_string expected %b actual %b", $time, want.eos,
                           rsp_bus.end_of_string);
                  fault_count++;
               end
            end
         end
      end
   end

   // Watchdog: any transfer on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL gbk_unicode_table_converter_unit");
         $finish;
      end
   end

   // Waits until every queued item has been transferred and every result has come,
   // then lets the pipeline run dry, since a lead byte or a table load gives no result.
   task automatic settle();
      while (pending_items.size() != 0 || req_bus.valid || due_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The limit register is only written between strings, with the block idle.
   task automatic set_max_length(input logic [15:0] value);
      settle();
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do
         @(posedge clock);
      while (!(csr_bus.valid && csr_bus.ready));
      csr_bus.valid <= 1'b0;
   endtask

   // Mostly well-formed strings with random content, with some noise in between:
   // items of any operation with random markers, which also break strings apart.
   // Bytes above 128 and CJK units come from the loaded sets only.
   task automatic queue_random_strings(input int unsigned quota);
      int unsigned made;
      int unsigned len;
      int unsigned k;
      bit decoding;
      req_item_type it;
      made = 0;
      while (made < quota) begin
         if ($urandom_range(9) < 2) begin
            it = any_item();
            if ($urandom_range(2) == 0)
               it.byte_in = '0;
            else if (it.byte_in > ASCII_LIMIT)
               it.byte_in = random_high();
            if (it.char_in >= CJK_FIRST && it.char_in <= CJK_LAST)
               it.char_in = random_cjk();
            pending_items.push_back(it);
            if (it.operation != OP_NONE)
               made++;
         end else begin
            decoding = $urandom_range(1);
            len = $urandom_range(1, 10);
            for (k = 0; k < len; k++) begin
               if (decoding) begin
                  if ($urandom_range(2) == 0) begin
                     pending_items.push_back(byte_item(8'($urandom_range(1, 128)), k == 0));
                  end else begin
                     // Double byte character; a few trails fall below 128.
                     pending_items.push_back(byte_item(random_high(), k == 0));
                     if ($urandom_range(4) == 0)
                        it = byte_item(8'($urandom_range(1, 127)), 1'b0);
                     else
                        it = byte_item(random_trail(), 1'b0);
                     pending_items.push_back(it);
                     made++;
                  end
               end else begin
                  case ($urandom_range(5))
                     0, 1: it = unit_item(16'($urandom_range(0, 255)), k == 0, k == len - 1);
                     2, 3: it = unit_item(random_cjk(), k == 0, k == len - 1);
                     4: it = unit_item(16'($urandom_range(256, CJK_FIRST - 1)), k == 0,
                                       k == len - 1);
                     default: it = unit_item(16'($urandom_range(CJK_LAST + 1, 16'hFFFF)),
                                             k == 0, k == len - 1);
                  endcase
                  pending_items.push_back(it);
               end
               made++;
            end
            // Most decoded strings close with a zero byte; the rest run into the next one.
            if (decoding && $urandom_range(3) != 0) begin
               pending_items.push_back(byte_item('0, 1'b0));
               made++;
            end
         end
      end
   endtask

   initial begin
      logic [15:0] limits [6];
      int unsigned i;
      int unsigned j;
      int unsigned slot;
      logic [7:0]  lead;
      logic [7:0]  trail;
      req_item_type it;

      req_bus.valid       = 1'b0;
      req_bus.operation   = OP_NONE;
      req_bus.table_index = '0;
      req_bus.table_word  = '0;
      req_bus.byte_in     = '0;
      req_bus.char_in     = '0;
      req_bus.first_item  = 1'b0;
      req_bus.last_item   = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.data        = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Load every entry that a decode or an encode of the stimulus can read,
      // plus the top index.
      for (i = 0; i < HIGH_COUNT; i++) begin
         lead = high_byte(i);
         for (j = 0; j <= HIGH_COUNT; j++) begin
            trail = (j == HIGH_COUNT) ? ASCII_LIMIT : high_byte(j);
            slot  = (lead - LEAD_BASE) * TRAIL_SPAN + (trail - ASCII_LIMIT);
            pending_items.push_back(load_item(16'(slot)));
         end
      end
      for (i = 0; i < CJK_COUNT; i++)
         pending_items.push_back(load_item(16'(cjk_unit(i) - CJK_FIRST + CJK_TABLE_BASE)));
      pending_items.push_back(load_item(16'hFFFF));

      // Unlimited length: single bytes up to 128, lowest and highest table pairs,
      // a trail byte below 128, and an encode unit between a lead and its trail.
      set_max_length('0);
      pending_items.push_back(byte_item(8'h41, 1'b1));
      pending_items.push_back(byte_item(ASCII_LIMIT, 1'b0));
      pending_items.push_back(byte_item(8'h81, 1'b0));
      pending_items.push_back(byte_item(8'h80, 1'b0));
      pending_items.push_back(byte_item(8'hFF, 1'b0));
      pending_items.push_back(byte_item(8'hFF, 1'b0));
      pending_items.push_back(byte_item(8'hB0, 1'b0));
      pending_items.push_back(byte_item(8'h7F, 1'b0));
      pending_items.push_back(byte_item(8'hC1, 1'b0));
      pending_items.push_back(unit_item(CJK_FIRST, 1'b0, 1'b0));
      pending_items.push_back(byte_item(8'hA0, 1'b0));
      // A table load and an unused operation with the first marker set must not
      // disturb the held lead byte.
      pending_items.push_back(byte_item(8'hA0, 1'b0));
      it = load_item(16'hFFFF);
      it.first_item = 1'b1;
      pending_items.push_back(it);
      it = any_item();
      it.operation  = OP_NONE;
      it.first_item = 1'b1;
      pending_items.push_back(it);
      pending_items.push_back(byte_item(8'h95, 1'b0));
      // Zero lead byte closes the string; an encode after it is swallowed.
      pending_items.push_back(byte_item('0, 1'b0));
      pending_items.push_back(unit_item(16'h0041, 1'b0, 1'b1));
      // Zero trail byte closes the string and drops the lead.
      pending_items.push_back(byte_item(8'hA5, 1'b1));
      pending_items.push_back(byte_item('0, 1'b0));
      // Encode classes at their edges.
      pending_items.push_back(unit_item('0, 1'b1, 1'b0));
      pending_items.push_back(unit_item(16'h00FF, 1'b0, 1'b0));
      pending_items.push_back(unit_item(16'(CJK_FIRST - 16'd1), 1'b0, 1'b0));
      pending_items.push_back(unit_item(CJK_LAST, 1'b0, 1'b0));
      pending_items.push_back(unit_item(16'(CJK_LAST + 16'd1), 1'b0, 1'b0));
      pending_items.push_back(unit_item(16'hFFFF, 1'b0, 1'b1));

      // Limit of three: trail bytes count, and the fourth unit of an encode is dropped.
      set_max_length(16'd3);
      pending_items.push_back(byte_item(8'h81, 1'b1));
      pending_items.push_back(byte_item(8'h41, 1'b0));
      pending_items.push_back(byte_item(8'h42, 1'b0));
      pending_items.push_back(unit_item(16'h0041, 1'b1, 1'b0));
      pending_items.push_back(unit_item(16'h0042, 1'b0, 1'b0));
      pending_items.push_back(unit_item(CJK_FIRST, 1'b0, 1'b0));
      pending_items.push_back(unit_item(16'h0044, 1'b0, 1'b1));

      limits = '{16'd1, 16'd0, 16'd2, 16'd7, 16'($urandom_range(1, 20)), 16'hFFFF};
      for (i = 0; i < 6; i++) begin
         // Last part, no idling, under the highest limit.
         if (i == 5)
            calm = 1'b1;
         set_max_length(limits[i]);
         pending_items.push_back(byte_item(8'h41, 1'b1));
         queue_random_strings(40);
      end

      settle();
      if (fault_count == 0)
         $display("PASS gbk_unicode_table_converter_unit");
      else
         $display("FAIL gbk_unicode_table_converter_unit");
      $finish;
   end

endmodule
